### design/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg - shared definitions of the bitmap font text console
// Constants, command codes, register indexes and the structures that pass
// between the register file, the cursor unit and the row emitter.
// ----------------------------------------------------------------------------
package bfc_pkg;

  localparam int FONT_BYTES = 4096;
  localparam int GLYPH_ROWS = 16;
  localparam int FONT_AW    = $clog2(FONT_BYTES);
  localparam int ROW_IDX_W  = $clog2(GLYPH_ROWS);

  localparam int COORD_W    = 13;
  localparam int PITCH_W    = 14;
  localparam int STRIDE_W   = 5;
  localparam int XPOS_W     = 15;
  localparam int CELL_W     = 8;
  localparam int ROW_MAX    = 8191;

  localparam int PADDR_W    = 6;
  localparam int PDATA_W    = 64;

  // Command codes carried in the mode field
  localparam logic [2:0] MODE_PUT_CHAR  = 3'd0;
  localparam logic [2:0] MODE_NEWLINE   = 3'd1;
  localparam logic [2:0] MODE_CENTER    = 3'd2;
  localparam logic [2:0] MODE_BACKSPACE = 3'd3;
  localparam logic [2:0] MODE_FONT_LOAD = 3'd4;

  // Register indexes (byte address is eight times the index)
  localparam logic [2:0] REG_FRAME_BASE    = 3'd0;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd1;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd2;
  localparam logic [2:0] REG_LINE_PITCH    = 3'd3;
  localparam logic [2:0] REG_INK_COLOUR    = 3'd4;
  localparam logic [2:0] REG_BLANK_COLOUR  = 3'd5;
  localparam logic [2:0] REG_GLYPH_STRIDE  = 3'd6;

  typedef struct packed {
    logic [63:0]          frame_base;
    logic [COORD_W-1:0]   screen_width;
    logic [COORD_W-1:0]   screen_height;
    logic [PITCH_W-1:0]   line_pitch;
    logic [31:0]          ink_colour;
    logic [31:0]          blank_colour;
    logic [STRIDE_W-1:0]  glyph_stride;
  } cfg_t;

  // One cell to be written: left column (two's complement), top row,
  // first glyph byte and colour.
  typedef struct packed {
    logic                 glyph;
    logic [XPOS_W-1:0]    x0;
    logic [COORD_W-1:0]   y0;
    logic [FONT_AW-1:0]   font_addr;
    logic [31:0]          colour;
  } cell_t;

endpackage

### design/bfc_ram.sv
// ----------------------------------------------------------------------------
// bfc_ram - generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/bfc_regs.sv
// ----------------------------------------------------------------------------
// bfc_regs - configuration register file
// APB-style slave holding the frame geometry, colours and glyph stride.
// ----------------------------------------------------------------------------
module bfc_regs import bfc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] index;

  assign pready = 1'b1;
  assign index  = paddr[PADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_base    <= '0;
      cfg.screen_width  <= COORD_W'(640);
      cfg.screen_height <= COORD_W'(480);
      cfg.line_pitch    <= PITCH_W'(640);
      cfg.ink_colour    <= 32'hFFFF_FFFF;
      cfg.blank_colour  <= '0;
      cfg.glyph_stride  <= STRIDE_W'(16);
    end else if (wr_en) begin
      unique case (index)
        REG_FRAME_BASE:    cfg.frame_base    <= pwdata;
        REG_SCREEN_WIDTH:  cfg.screen_width  <= pwdata[COORD_W-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[COORD_W-1:0];
        REG_LINE_PITCH:    cfg.line_pitch    <= pwdata[PITCH_W-1:0];
        REG_INK_COLOUR:    cfg.ink_colour    <= pwdata[31:0];
        REG_BLANK_COLOUR:  cfg.blank_colour  <= pwdata[31:0];
        REG_GLYPH_STRIDE:  cfg.glyph_stride  <= pwdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_FRAME_BASE:    prdata = cfg.frame_base;
      REG_SCREEN_WIDTH:  prdata = PDATA_W'(cfg.screen_width);
      REG_SCREEN_HEIGHT: prdata = PDATA_W'(cfg.screen_height);
      REG_LINE_PITCH:    prdata = PDATA_W'(cfg.line_pitch);
      REG_INK_COLOUR:    prdata = PDATA_W'(cfg.ink_colour);
      REG_BLANK_COLOUR:  prdata = PDATA_W'(cfg.blank_colour);
      REG_GLYPH_STRIDE:  prdata = PDATA_W'(cfg.glyph_stride);
      default:           prdata = '0;
    endcase
  end

endmodule

### design/bfc_cursor.sv
// ----------------------------------------------------------------------------
// bfc_cursor - text cursor unit
// Moves the cursor on accepted put-character, newline, center and backspace
// commands, and captures the cell that a put-character or backspace writes.
// ----------------------------------------------------------------------------
module bfc_cursor import bfc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [2:0]   mode,
  input  logic [7:0]   char_code,
  input  cfg_t         cfg,
  output cell_t        tile
);

  logic [COORD_W-1:0]        col;
  logic [COORD_W-1:0]        row;
  logic [COORD_W-1:0]        col_next;
  logic [COORD_W-1:0]        row_next;
  logic [COORD_W-1:0]        bs_col;
  logic [COORD_W-1:0]        bs_row;
  logic [XPOS_W-1:0]         col_plus8;
  logic [XPOS_W-1:0]         col_plus16;
  logic [7+STRIDE_W:0]       glyph_start;
  cell_t                     tile_next;

  function automatic logic [COORD_W-1:0] row_forward(input logic [COORD_W-1:0] r);
    logic [COORD_W:0] s;
    s = {1'b0, r} + (COORD_W+1)'(GLYPH_ROWS);
    return (s > (COORD_W+1)'(ROW_MAX)) ? COORD_W'(ROW_MAX) : s[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] row_back(input logic [COORD_W-1:0] r);
    return (r >= COORD_W'(GLYPH_ROWS)) ? r - COORD_W'(GLYPH_ROWS) : '0;
  endfunction

  always_comb begin
    col_plus8   = {2'b00, col} + XPOS_W'(CELL_W);
    col_plus16  = {2'b00, col} + XPOS_W'(2 * CELL_W);
    glyph_start = char_code * cfg.glyph_stride;

    // Backspace first steps back over the start of a line
    bs_col = (col == '0) ? cfg.screen_width : col;
    bs_row = (col == '0) ? row_back(row) : row;

    col_next  = col;
    row_next  = row;
    tile_next = tile;

    case (mode)
      MODE_PUT_CHAR: begin
        tile_next.glyph     = 1'b1;
        tile_next.x0        = {2'b00, col};
        tile_next.y0        = row;
        tile_next.font_addr = glyph_start[FONT_AW-1:0];
        tile_next.colour    = cfg.ink_colour;
        if (col_plus16 > {2'b00, cfg.screen_width}) begin
          col_next = '0;
          row_next = row_forward(row);
        end else begin
          col_next = col_plus8[COORD_W-1:0];
        end
      end
      MODE_NEWLINE: begin
        col_next = '0;
        row_next = row_forward(row);
      end
      MODE_CENTER: begin
        col_next = cfg.screen_width >> 1;
      end
      MODE_BACKSPACE: begin
        tile_next.glyph     = 1'b0;
        tile_next.x0        = {2'b00, bs_col} - XPOS_W'(CELL_W);
        tile_next.y0        = bs_row;
        tile_next.font_addr = '0;
        tile_next.colour    = cfg.blank_colour;
        if (bs_col < COORD_W'(CELL_W)) begin
          col_next = cfg.screen_width;
          row_next = row_back(bs_row);
        end else begin
          col_next = bs_col - COORD_W'(CELL_W);
          row_next = bs_row;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tile <= tile_next;
    end
  end

endmodule

### design/bitmap_font_text_console_core.sv
// ----------------------------------------------------------------------------
// bitmap_font_text_console_core - text console renderer with bitmap font
// Keeps a loadable 8-pixel-wide font and a text cursor and turns character
// commands into framebuffer row writes.
// ----------------------------------------------------------------------------
// Each request is one command. A font load, newline, center or unused
// command is taken and produces no row write. A put character or backspace
// command first works out the cell: on acceptance the cursor moves and the
// cell is captured, S_MUL forms the row times pitch product, column window
// and visible row count, and S_BASE forms the base address. It then emits
// one row write per cycle unless out_ready stalls it, up to sixteen. That
// pace is set by the font memory: its single read port delivers one glyph
// byte per cycle, and the next byte is fetched ahead so that the output
// register can be reloaded every cycle. The output register decouples the
// two sides, so the next command is taken while the last row of a character
// is still waiting to be collected. Row writes that fall wholly below the
// screen are not issued, columns beyond either screen edge are cleared from
// the mask, and a cell with no visible column gives no writes at all. Font
// bytes must be loaded before they are read; the block does not enforce it.
// ----------------------------------------------------------------------------
module bitmap_font_text_console_core import bfc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // command requests
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic [7:0]         char_code,
  input  logic [11:0]        font_index,
  input  logic [7:0]         font_byte,
  // row write requests
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        row_address,
  output logic [7:0]         row_mask,
  output logic [31:0]        row_colour,
  output logic               last_row
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_BASE,
    S_EMIT
  } state_t;

  state_t                         state;
  cfg_t                           cfg;
  cell_t                          tile;
  logic                           accept;
  logic                           draw_cmd;
  logic                           load;
  logic [COORD_W+PITCH_W-1:0]     prod;
  logic [7:0]                     window;
  logic [ROW_IDX_W-1:0]           last_idx;
  logic [ROW_IDX_W-1:0]           rd_row;
  logic [FONT_AW-1:0]             rd_addr;
  logic [FONT_AW-1:0]             ram_raddr;
  logic [7:0]                     ram_q;
  logic [63:0]                    cur_addr;
  logic [30:0]                    offset;
  logic [COORD_W-1:0]             rows_left;
  logic                           visible;
  logic [7:0]                     window_calc;

  // Columns x0 .. x0+7 that lie on the screen; bit 7 is the leftmost.
  function automatic logic [7:0] column_window(input logic [XPOS_W-1:0] x0,
                                               input logic [COORD_W-1:0] sw);
    logic [7:0]        m;
    logic signed [XPOS_W:0] x;
    m = '0;
    for (int i = 0; i < CELL_W; i++) begin
      x = $signed({x0[XPOS_W-1], x0}) + $signed((XPOS_W+1)'(i));
      if (x >= 0 && x < $signed({3'b000, sw})) begin
        m[7-i] = 1'b1;
      end
    end
    return m;
  endfunction

  bfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // No request is taken while reset is held, so none can be lost there.
  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign draw_cmd = (mode == MODE_PUT_CHAR) || (mode == MODE_BACKSPACE);

  bfc_cursor u_cursor (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (mode),
    .char_code (char_code),
    .cfg       (cfg),
    .tile      (tile)
  );

  // Font store: written by font load requests, read one glyph row ahead
  // of the output register.
  assign load = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    if (state == S_BASE) begin
      ram_raddr = tile.font_addr;
    end else if (load) begin
      ram_raddr = rd_addr + FONT_AW'(1);
    end else begin
      ram_raddr = rd_addr;
    end
  end

  bfc_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font (
    .clk   (clk),
    .we    (accept && (mode == MODE_FONT_LOAD)),
    .waddr (font_index[FONT_AW-1:0]),
    .wdata (font_byte),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Cell geometry, evaluated from the captured cell
  assign window_calc = column_window(tile.x0, cfg.screen_width);
  assign visible     = (window_calc != '0) && (tile.y0 < cfg.screen_height);
  assign rows_left   = cfg.screen_height - tile.y0;
  assign offset      = {2'b00, prod, 2'b00} + {{14{tile.x0[XPOS_W-1]}}, tile.x0, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && draw_cmd) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod   <= tile.y0 * cfg.line_pitch;
          window <= window_calc;
          if (rows_left >= COORD_W'(GLYPH_ROWS)) begin
            last_idx <= ROW_IDX_W'(GLYPH_ROWS - 1);
          end else begin
            last_idx <= ROW_IDX_W'(rows_left - COORD_W'(1));
          end
          state <= visible ? S_BASE : S_IDLE;
        end
        S_BASE: begin
          cur_addr <= cfg.frame_base + {{33{offset[30]}}, offset};
          rd_addr  <= tile.font_addr;
          rd_row   <= '0;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            out_valid   <= 1'b1;
            row_address <= cur_addr;
            row_mask    <= tile.glyph ? (window & ram_q) : window;
            row_colour  <= tile.colour;
            last_row    <= (rd_row == last_idx);
            if (rd_row == last_idx) begin
              state <= S_IDLE;
            end else begin
              rd_row   <= rd_row + ROW_IDX_W'(1);
              rd_addr  <= rd_addr + FONT_AW'(1);
              cur_addr <= cur_addr + {48'd0, cfg.line_pitch, 2'b00};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
